@@ design/ifp_pkg.sv @@
package ifp_pkg;

  localparam int FRAME_LENGTH_DEF = 11;
  localparam int STORE_DEPTH = 9;
  localparam int CFG_IDX_W = 2;
  localparam logic [7:0] SYNC_RESET = 8'h55;
  localparam logic [7:0] TYPE_RESET = 8'h53;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_TYPE  = 2'd1,
    PH_BODY  = 2'd2,
    PH_JUDGE = 2'd3
  } ifp_phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       consumer_busy;
  } ifp_in_t;

  typedef struct packed {
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] roll_degrees;
    logic signed [15:0] pitch_degrees;
    logic signed [15:0] yaw_degrees;
  } ifp_out_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
  } ifp_cfg_wr_t;

  typedef struct packed {
    logic     valid;
    ifp_out_t data;
  } ifp_result_t;

  // Degrees as (raw * 180) >>> 8; the product fits in 24 bits.
  function automatic logic signed [15:0] to_degrees(input logic signed [15:0] raw);
    logic [23:0] prod;
    prod = {{8{raw[15]}}, raw} * 24'd180;
    return prod[23:8];
  endfunction

endpackage

@@ design/ifp_parser.sv @@
module ifp_parser #(
  parameter int FRAME_LENGTH = ifp_pkg::FRAME_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_acc,
  input  ifp_pkg::ifp_in_t     byte_in,
  input  ifp_pkg::ifp_cfg_wr_t cfg_wr,
  output ifp_pkg::ifp_result_t result
);

  localparam int CNT_W = $clog2(FRAME_LENGTH);

  logic [7:0]          sync_r;
  logic [7:0]          type_r;
  ifp_pkg::ifp_phase_t phase_r, phase_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [7:0]          sum_r, sum_nxt;
  logic [7:0]          check_r;
  logic                fresh_r, fresh_nxt;
  logic                check_load;
  logic                last_byte;
  logic                sum_ok;
  logic [7:0]          store_r [ifp_pkg::STORE_DEPTH];
  logic [7:0]          b;

  assign b         = byte_in.rx_byte;
  assign last_byte = (int'(count_r) + 1 >= FRAME_LENGTH);
  assign sum_ok    = (check_r == sum_r) && !byte_in.consumer_busy;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    sum_nxt    = sum_r;
    fresh_nxt  = fresh_r;
    check_load = 1'b0;
    if (byte_acc) begin
      case (phase_r)
        ifp_pkg::PH_HUNT: begin
          if (b == sync_r) begin
            phase_nxt = ifp_pkg::PH_TYPE;
            sum_nxt   = b;
            count_nxt = CNT_W'(1);
          end else begin
            count_nxt = '0;
            sum_nxt   = '0;
          end
        end
        ifp_pkg::PH_TYPE: begin
          if (b == type_r) begin
            phase_nxt = ifp_pkg::PH_BODY;
            sum_nxt   = sum_r + b;
            count_nxt = CNT_W'(2);
          end else begin
            phase_nxt = ifp_pkg::PH_HUNT;
            count_nxt = '0;
            sum_nxt   = '0;
          end
        end
        ifp_pkg::PH_BODY: begin
          if (last_byte) begin
            check_load = 1'b1;
            phase_nxt  = ifp_pkg::PH_JUDGE;
            fresh_nxt  = 1'b1;
            count_nxt  = '0;
          end else begin
            sum_nxt   = sum_r + b;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        ifp_pkg::PH_JUDGE: begin
          if (sum_ok) begin
            fresh_nxt = 1'b0;
          end
          phase_nxt = ifp_pkg::PH_HUNT;
          count_nxt = '0;
          sum_nxt   = '0;
        end
        default: begin
          phase_nxt = ifp_pkg::PH_HUNT;
          count_nxt = '0;
          sum_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r  <= ifp_pkg::SYNC_RESET;
      type_r  <= ifp_pkg::TYPE_RESET;
      phase_r <= ifp_pkg::PH_HUNT;
      count_r <= '0;
      sum_r   <= '0;
      fresh_r <= 1'b0;
    end else begin
      if (cfg_wr.valid && cfg_wr.index == ifp_pkg::CFG_SYNC) begin
        sync_r <= cfg_wr.data;
      end
      if (cfg_wr.valid && cfg_wr.index == ifp_pkg::CFG_TYPE) begin
        type_r <= cfg_wr.data;
      end
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (check_load) begin
      check_r <= b;
    end
    for (int i = 0; i < ifp_pkg::STORE_DEPTH; i++) begin
      if (byte_acc && phase_r == ifp_pkg::PH_BODY && int'(count_r) == i + 2) begin
        store_r[i] <= b;
      end
    end
  end

  always_comb begin
    result.valid = byte_acc && phase_r == ifp_pkg::PH_JUDGE && sum_ok && fresh_r;
    result.data.roll_raw      = {store_r[1], store_r[0]};
    result.data.pitch_raw     = {store_r[3], store_r[2]};
    result.data.yaw_raw       = {store_r[5], store_r[4]};
    result.data.roll_degrees  = ifp_pkg::to_degrees(result.data.roll_raw);
    result.data.pitch_degrees = ifp_pkg::to_degrees(result.data.pitch_raw);
    result.data.yaw_degrees   = ifp_pkg::to_degrees(result.data.yaw_raw);
  end

endmodule

@@ design/ifp_out_buf.sv @@
module ifp_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ifp_pkg::ifp_result_t result,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ifp_pkg::ifp_out_t    out_data
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  ifp_pkg::ifp_out_t main_data_r, main_data_nxt;
  ifp_pkg::ifp_out_t skid_data_r, skid_data_nxt;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (!main_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        main_data_nxt  = skid_data_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_data_nxt  = result.data;
        main_valid_nxt = result.valid;
      end
    end else if (result.valid) begin
      skid_data_nxt  = result.data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule

@@ design/imu_angle_frame_parser_top.sv @@
// Angle frame parser: takes one received byte per cycle while not stalled, hunts for the sync
// and type bytes, collects the frame body and judges the checksum on the word that follows the
// frame, which is always dropped. A good frame with the consumer not busy gives one result
// word, put in the output register, or in the spare stage while the output is held. Throughput
// is one word per cycle; the input stalls only when both the output register and the spare stage
// behind it hold results the receiver has not taken. The user must write the sync and type
// bytes through the configuration port only while idle; the block itself does not enforce it.
module imu_angle_frame_parser_top #(
  parameter int FRAME_LENGTH = ifp_pkg::FRAME_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ifp_pkg::ifp_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ifp_pkg::ifp_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ifp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_wdata
);

  logic                 in_acc;
  ifp_pkg::ifp_cfg_wr_t cfg_wr;
  ifp_pkg::ifp_result_t result;

  assign cfg_ready    = 1'b1;
  assign in_acc       = in_valid && !in_stall;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_wdata;

  ifp_parser #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (in_acc),
    .byte_in  (in_data),
    .cfg_wr   (cfg_wr),
    .result   (result)
  );

  ifp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A result can only come from an accepted word.
  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    result.valid |-> in_acc)
    else $error("result without an accepted word");

  // The spare stage is only occupied behind a full output register.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with output register empty");

  // The spare stage fills only when the output was held by the receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall rose without a held output word");

endmodule
